// ===== hdl/sparse_image_block_translator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sparse image block translator: assertion macros
// Shared property forms for the checker of the translator core.
// ----------------------------------------------------------------------------
`ifndef SPARSE_IMAGE_BLOCK_TRANSLATOR_CORE_DEFINES_SVH
`define SPARSE_IMAGE_BLOCK_TRANSLATOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SIBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SIBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sibt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse image block translator package
// Types, codes, sizes and the sequencer program of the translator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sibt_pkg;

  localparam int MAP_DEPTH  = 4096;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int MAX_CHUNKS = 16;
  localparam int ZMASK_W    = 16;
  localparam int CHUNK_CAP  = (MAX_CHUNKS < ZMASK_W) ? MAX_CHUNKS : ZMASK_W;
  localparam int K_W        = $clog2(ZMASK_W);

  localparam int OFF_W   = 48;
  localparam int LEN_W   = 21;
  localparam int HOST_W  = 20;
  localparam int ADDR_W  = 49;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 13;
  localparam int SHIFT_W = 5;
  localparam int BLK_W   = 39;
  localparam int OIN_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 5'd9;
  localparam logic [LEN_W-1:0]   MAX_LEN     = 21'h10_0000;
  localparam logic [WORD_W-1:0]  SPARSE_MARK = 32'hffff_fffe;

  localparam logic [SHIFT_W-1:0]    RST_BLOCK_SHIFT = 5'd20;
  localparam logic                  RST_GROWABLE    = 1'b1;
  localparam logic [CNT_W-1:0]      RST_BLOCKS      = 13'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_DATA_OFFSET = '0;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_LOAD_MAP  = 3'd2,
    CMD_SET_ALLOC = 3'd3,
    CMD_CLR_DIRTY = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_READ         = 3'd0,
    ACT_ZERO_FILL    = 3'd1,
    ACT_WRITE        = 3'd2,
    ACT_WRITE_PADDED = 3'd3,
    ACT_STAYS_ZERO   = 3'd4,
    ACT_NONE         = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_TOO_MANY  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SHIFT = 2'd0,
    CFG_GROWABLE    = 2'd1,
    CFG_BLOCKS      = 2'd2,
    CFG_DATA_OFFSET = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  request_length;
    logic [ZMASK_W-1:0] zero_mask;
    logic [11:0]       map_index;
    logic [WORD_W-1:0] map_value;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] image_address;
    logic [HOST_W-1:0] host_offset;
    logic [LEN_W-1:0]  chunk_length;
    action_e           action;
    status_e           status;
    logic              dirty;
    logic              last;
  } out_item_t;

  // sequencer program
  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_COUNT  = 3'd1,
    STEP_CHUNK  = 3'd2,
    STEP_LOOKUP = 3'd3,
    STEP_ADDR   = 3'd4,
    STEP_EMIT   = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    OP_ACCEPT = 3'd0,
    OP_COUNT  = 3'd1,
    OP_CHUNK  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_ADDR   = 3'd4,
    OP_EMIT   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_RW     = 3'd1,
    COND_EARLY  = 3'd2,
    COND_RANGE  = 3'd3,
    COND_FULL   = 3'd4,
    COND_LAST   = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    logic  hold_out;
    cond_e cond;
    step_e jump_step;
    step_e next_step;
  } uword_t;

  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      STEP_IDLE:   w = '{OP_ACCEPT, 1'b0, COND_RW,     STEP_COUNT, STEP_IDLE};
      STEP_COUNT:  w = '{OP_COUNT,  1'b0, COND_EARLY,  STEP_EMIT,  STEP_CHUNK};
      STEP_CHUNK:  w = '{OP_CHUNK,  1'b0, COND_RANGE,  STEP_EMIT,  STEP_LOOKUP};
      STEP_LOOKUP: w = '{OP_LOOKUP, 1'b0, COND_FULL,   STEP_EMIT,  STEP_ADDR};
      STEP_ADDR:   w = '{OP_ADDR,   1'b0, COND_ALWAYS, STEP_EMIT,  STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,   1'b1, COND_LAST,   STEP_IDLE,  STEP_CHUNK};
      default:     w = '{OP_ACCEPT, 1'b0, COND_ALWAYS, STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/sibt_if.sv =====
// ----------------------------------------------------------------------------
// Sparse image block translator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sibt_in_if;
  logic               valid;
  logic               ready;
  sibt_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface sibt_out_if;
  logic                valid;
  logic                ready;
  sibt_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/sparse_image_block_translator_core.sv =====
// ----------------------------------------------------------------------------
// Sparse image block translator core
// Splits disk requests into per-block image chunks through a block map.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries commands. Map loads, allocated count writes and dirty
//   clears are taken in the idle step and give no result. A read or write gives
//   one result item per block touched on res_o, the final one with last set.
//   An empty request, a request over the chunk limit, a block outside the map
//   and a full image each end the item with a single action-none result.
//   Steps: take the item, count its chunks, then per chunk range check and
//   map read, map update, address add and hand-off, each a sequencer step.
//   A new item is taken once the last result has entered the output register.
//   When the receiver stalls, the output register holds its item and the
//   sequencer waits in its hand-off step; nothing is dropped.
//   Reset clears the sequencer, output valid, allocated count and dirty flag
//   and loads the register defaults; the block map is not cleared and must be
//   loaded before use. cfg_we_i writes a register per cycle, no read-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_image_block_translator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sibt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sibt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  sibt_in_if.sink                              req_i,
  sibt_out_if.source                           res_o
);

  // configuration
  logic [sibt_pkg::SHIFT_W-1:0]    block_shift_q;
  logic                            growable_q;
  logic [sibt_pkg::CNT_W-1:0]      blocks_q;
  logic [sibt_pkg::CFG_DATA_W-1:0] data_offset_q;

  // sequencer
  sibt_pkg::step_e  step_q, step_d;
  sibt_pkg::uword_t uw;
  logic             cond_hit;

  // persistent state
  logic [sibt_pkg::CNT_W-1:0] alloc_q;
  logic                       dirty_q;

  // per-item datapath
  logic                         wr_q;
  logic [sibt_pkg::ZMASK_W-1:0] zmask_q;
  logic [sibt_pkg::K_W-1:0]     k_q;
  logic [sibt_pkg::SHIFT_W-1:0] shift_q;
  logic [sibt_pkg::BLK_W-1:0]   blk_q;
  logic [sibt_pkg::OIN_W-1:0]   oin_q;
  logic [sibt_pkg::LEN_W-1:0]   rem_q;
  logic [sibt_pkg::HOST_W-1:0]  host_q;
  logic [sibt_pkg::LEN_W-1:0]   ch_q;
  logic [sibt_pkg::ADDR_W-1:0]  base_q;
  logic                         addr_used_q;

  // staged result
  logic [sibt_pkg::ADDR_W-1:0] res_addr_q;
  logic [sibt_pkg::HOST_W-1:0] res_host_q;
  logic [sibt_pkg::LEN_W-1:0]  res_len_q;
  sibt_pkg::action_e           res_act_q;
  sibt_pkg::status_e           res_stat_q;
  logic                        res_last_q;

  // output register
  logic                out_valid_q;
  sibt_pkg::out_item_t out_q;
  logic                out_busy;

  // block map
  logic [sibt_pkg::WORD_W-1:0] map_mem [sibt_pkg::MAP_DEPTH];
  logic [sibt_pkg::WORD_W-1:0] map_rd_q;
  logic                        map_we;
  logic                        map_re;
  logic [sibt_pkg::MAP_AW-1:0] map_wa;
  logic [sibt_pkg::WORD_W-1:0] map_wd;

  // combinational terms
  logic                         accept;
  logic                         acc_rw;
  logic [sibt_pkg::SHIFT_W-1:0] acc_shift;
  logic [sibt_pkg::LEN_W-1:0]   acc_len;
  logic [31:0]                  bs;
  logic [31:0]                  room;
  logic [32:0]                  span;
  logic [32:0]                  nch;
  logic                         early;
  logic [sibt_pkg::LEN_W-1:0]   chunk_len;
  logic                         out_range;
  logic                         sparse;
  logic                         zbit;
  logic                         lk_full;
  logic                         lk_we;
  logic [sibt_pkg::WORD_W-1:0]  lk_wd;
  logic                         lk_dirty;
  logic                         lk_alloc;
  logic                         lk_addr_used;
  logic [sibt_pkg::ADDR_W-1:0]  lk_base;
  sibt_pkg::action_e            lk_act;

  assign uw       = sibt_pkg::ucode(step_q);
  assign req_i.ready = (uw.op == sibt_pkg::OP_ACCEPT);
  assign accept   = req_i.valid && req_i.ready;
  assign acc_rw   = (req_i.item.cmd == sibt_pkg::CMD_READ) ||
                    (req_i.item.cmd == sibt_pkg::CMD_WRITE);
  assign acc_shift = (block_shift_q < sibt_pkg::MIN_SHIFT) ? sibt_pkg::MIN_SHIFT
                                                           : block_shift_q;
  assign acc_len  = (req_i.item.request_length > sibt_pkg::MAX_LEN) ? sibt_pkg::MAX_LEN
                                                                    : req_i.item.request_length;

  assign bs    = 32'd1 << shift_q;
  assign room  = bs - 32'(oin_q);
  assign span  = 33'(oin_q) + 33'(rem_q) + 33'(bs) - 33'd1;
  assign nch   = span >> shift_q;
  assign early = (rem_q == '0) || (nch > 33'(sibt_pkg::CHUNK_CAP));
  assign chunk_len = (room > 32'(rem_q)) ? rem_q : sibt_pkg::LEN_W'(room);
  assign out_range = (blk_q >= sibt_pkg::BLK_W'(blocks_q)) ||
                     (blk_q >= sibt_pkg::BLK_W'(sibt_pkg::MAP_DEPTH));

  assign out_busy  = out_valid_q && !res_o.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.item  = out_q;

  always_comb begin
    sparse       = growable_q && (map_rd_q >= sibt_pkg::SPARSE_MARK);
    zbit         = zmask_q[k_q];
    lk_full      = 1'b0;
    lk_we        = 1'b0;
    lk_wd        = sibt_pkg::SPARSE_MARK;
    lk_dirty     = 1'b0;
    lk_alloc     = 1'b0;
    lk_addr_used = 1'b1;
    lk_base      = (sibt_pkg::ADDR_W'(map_rd_q) << shift_q) | sibt_pkg::ADDR_W'(oin_q);
    lk_act       = sibt_pkg::ACT_READ;
    if (!wr_q) begin
      if (sparse) begin
        lk_act       = sibt_pkg::ACT_ZERO_FILL;
        lk_addr_used = 1'b0;
      end
    end else if (!sparse) begin
      lk_act = sibt_pkg::ACT_WRITE;
    end else if (zbit) begin
      lk_act       = sibt_pkg::ACT_STAYS_ZERO;
      lk_addr_used = 1'b0;
      lk_we        = 1'b1;
      lk_dirty     = (map_rd_q != sibt_pkg::SPARSE_MARK);
    end else if (alloc_q >= blocks_q) begin
      lk_full      = 1'b1;
      lk_act       = sibt_pkg::ACT_NONE;
      lk_addr_used = 1'b0;
    end else begin
      lk_act   = sibt_pkg::ACT_WRITE_PADDED;
      lk_we    = 1'b1;
      lk_wd    = sibt_pkg::WORD_W'(alloc_q);
      lk_dirty = 1'b1;
      lk_alloc = 1'b1;
      lk_base  = sibt_pkg::ADDR_W'(alloc_q) << shift_q;
    end
  end

  always_comb begin
    map_re = (uw.op == sibt_pkg::OP_CHUNK);
    if (uw.op == sibt_pkg::OP_ACCEPT) begin
      map_we = accept && (req_i.item.cmd == sibt_pkg::CMD_LOAD_MAP) &&
               (32'(req_i.item.map_index) < 32'(sibt_pkg::MAP_DEPTH));
      map_wa = sibt_pkg::MAP_AW'(req_i.item.map_index);
      map_wd = req_i.item.map_value;
    end else begin
      map_we = (uw.op == sibt_pkg::OP_LOOKUP) && lk_we;
      map_wa = blk_q[sibt_pkg::MAP_AW-1:0];
      map_wd = lk_wd;
    end
  end

  always_comb begin
    case (uw.cond)
      sibt_pkg::COND_ALWAYS: cond_hit = 1'b1;
      sibt_pkg::COND_RW:     cond_hit = accept && acc_rw;
      sibt_pkg::COND_EARLY:  cond_hit = early;
      sibt_pkg::COND_RANGE:  cond_hit = out_range;
      sibt_pkg::COND_FULL:   cond_hit = lk_full;
      sibt_pkg::COND_LAST:   cond_hit = res_last_q;
      default:               cond_hit = 1'b0;
    endcase
    if (uw.hold_out && out_busy) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = uw.jump_step;
    end else begin
      step_d = uw.next_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_q <= map_mem[blk_q[sibt_pkg::MAP_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= sibt_pkg::STEP_IDLE;
      out_valid_q   <= 1'b0;
      alloc_q       <= '0;
      dirty_q       <= 1'b0;
      block_shift_q <= sibt_pkg::RST_BLOCK_SHIFT;
      growable_q    <= sibt_pkg::RST_GROWABLE;
      blocks_q      <= sibt_pkg::RST_BLOCKS;
      data_offset_q <= sibt_pkg::RST_DATA_OFFSET;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sibt_pkg::CFG_BLOCK_SHIFT: block_shift_q <= cfg_data_i[sibt_pkg::SHIFT_W-1:0];
          sibt_pkg::CFG_GROWABLE:    growable_q    <= cfg_data_i[0];
          sibt_pkg::CFG_BLOCKS:      blocks_q      <= cfg_data_i[sibt_pkg::CNT_W-1:0];
          sibt_pkg::CFG_DATA_OFFSET: data_offset_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (uw.op == sibt_pkg::OP_ACCEPT && accept) begin
        if (req_i.item.cmd == sibt_pkg::CMD_SET_ALLOC) begin
          alloc_q <= req_i.item.map_value[sibt_pkg::CNT_W-1:0];
        end
        if (req_i.item.cmd == sibt_pkg::CMD_CLR_DIRTY) begin
          dirty_q <= 1'b0;
        end
      end
      if (uw.op == sibt_pkg::OP_LOOKUP) begin
        if (lk_alloc) begin
          alloc_q <= alloc_q + 1'b1;
        end
        if (lk_dirty) begin
          dirty_q <= 1'b1;
        end
      end
      if (uw.op == sibt_pkg::OP_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.op)
      sibt_pkg::OP_ACCEPT: begin
        if (accept) begin
          wr_q    <= (req_i.item.cmd == sibt_pkg::CMD_WRITE);
          zmask_q <= req_i.item.zero_mask;
          shift_q <= acc_shift;
          blk_q   <= sibt_pkg::BLK_W'(req_i.item.byte_offset >> acc_shift);
          oin_q   <= sibt_pkg::OIN_W'(req_i.item.byte_offset &
                     ((48'd1 << acc_shift) - 48'd1));
          rem_q   <= acc_len;
          host_q  <= '0;
          k_q     <= '0;
        end
      end
      sibt_pkg::OP_COUNT: begin
        res_addr_q <= '0;
        res_host_q <= '0;
        res_len_q  <= '0;
        res_act_q  <= sibt_pkg::ACT_NONE;
        res_stat_q <= (rem_q == '0) ? sibt_pkg::STAT_OK : sibt_pkg::STAT_TOO_MANY;
        res_last_q <= 1'b1;
      end
      sibt_pkg::OP_CHUNK: begin
        ch_q       <= chunk_len;
        res_addr_q <= '0;
        res_host_q <= host_q;
        res_len_q  <= chunk_len;
        res_act_q  <= sibt_pkg::ACT_NONE;
        res_stat_q <= sibt_pkg::STAT_RANGE;
        res_last_q <= 1'b1;
      end
      sibt_pkg::OP_LOOKUP: begin
        base_q      <= lk_base;
        addr_used_q <= lk_addr_used;
        res_act_q   <= lk_act;
        res_stat_q  <= lk_full ? sibt_pkg::STAT_FULL : sibt_pkg::STAT_OK;
        res_last_q  <= lk_full || (rem_q == ch_q);
      end
      sibt_pkg::OP_ADDR: begin
        res_addr_q <= addr_used_q ? (sibt_pkg::ADDR_W'(data_offset_q) + base_q) : '0;
      end
      sibt_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_q.image_address <= res_addr_q;
          out_q.host_offset   <= res_host_q;
          out_q.chunk_length  <= res_len_q;
          out_q.action        <= res_act_q;
          out_q.status        <= res_stat_q;
          out_q.dirty         <= dirty_q;
          out_q.last          <= res_last_q;
          if (!res_last_q) begin
            rem_q  <= rem_q - ch_q;
            host_q <= host_q + sibt_pkg::HOST_W'(ch_q);
            blk_q  <= blk_q + 1'b1;
            oin_q  <= '0;
            k_q    <= k_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/sibt_checker.sv =====
// ----------------------------------------------------------------------------
// Sparse image block translator checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_image_block_translator_core_defines.svh"

module sibt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input sibt_pkg::out_item_t res_item_i
);

  `SIBT_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_item_i), "stalled result item changed")

  `SIBT_ASSERT_IMPLY(a_addr_zero, clk_i, rst_ni, res_valid_i && (res_item_i.action == sibt_pkg::ACT_ZERO_FILL || res_item_i.action == sibt_pkg::ACT_STAYS_ZERO || res_item_i.action == sibt_pkg::ACT_NONE), res_item_i.image_address == '0, "address set on an action without image access")

  `SIBT_ASSERT_IMPLY(a_err_ends, clk_i, rst_ni, res_valid_i && res_item_i.status != sibt_pkg::STAT_OK, res_item_i.action == sibt_pkg::ACT_NONE && res_item_i.last, "error result not final or has an action")

  `SIBT_ASSERT_IMPLY(a_too_many, clk_i, rst_ni, res_valid_i && res_item_i.status == sibt_pkg::STAT_TOO_MANY, res_item_i.host_offset == '0 && res_item_i.chunk_length == '0, "chunk-limit result carries a chunk")

endmodule

bind sparse_image_block_translator_core sibt_checker u_sibt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_item_i  (res_o.item)
);
